// ===== rtl/core/gpwa_pkg.sv =====
// Package of the grouped pair weight accumulator: field widths, register
// indexes and reset values, fixed-point constants and the root factor table.
// No dependencies.
package gpwa_pkg;

   localparam int MAX_CELLS_DEF   = 11;
   localparam int SCORE_WIDTH_DEF = 24;

   localparam int CELL_W   = 4;
   localparam int PEAK_W   = 24;
   localparam int DIST_W   = 16;
   localparam int PAIR_W   = 6;
   localparam int SCORE_W  = 24;
   localparam int THRESH_W = 24;
   localparam int INV_W    = 32;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int WEIGHT_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CELL_COUNT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SD_SQUARED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMIT_THRESHOLD = 2'd2;

   localparam logic [CELL_W-1:0]   CELL_COUNT_RST = 4'd11;
   localparam logic [INV_W-1:0]    INV_SD_RST     = 32'hFFFF_FFFF;
   localparam logic [THRESH_W-1:0] THRESHOLD_RST  = 24'd655;

   // log2(1/0.7788) as an unsigned Q0.32 fraction.
   localparam logic [31:0] LOG2_K = 32'd1549088188;
   // Exponent limit (48.0 in Q16) beyond which the weight is zero.
   localparam logic [47:0] X16_LIMIT = 48'd3145728;
   // Integer part of the log2 exponent at which the weight is zero.
   localparam logic [5:0]  N_LIMIT = 6'd17;
   localparam int ROOT_STEPS = 12;

   // Factor 2^-(2^-(k+1)) in Q1.30 for fraction bit k (k = 0 is the half bit).
   function automatic logic [29:0] root_factor(input logic [3:0] k);
      logic [29:0] r;
      case (k)
         4'd0:    r = 30'd759250125;
         4'd1:    r = 30'd902905651;
         4'd2:    r = 30'd984625594;
         4'd3:    r = 30'd1028218694;
         4'd4:    r = 30'd1050733823;
         4'd5:    r = 30'd1062175527;
         4'd6:    r = 30'd1067943017;
         4'd7:    r = 30'd1070838496;
         4'd8:    r = 30'd1072289178;
         4'd9:    r = 30'd1073015255;
         4'd10:   r = 30'd1073378480;
         4'd11:   r = 30'd1073560135;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/gpwa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module gpwa_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 55,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/grouped_pair_weight_accumulator.sv =====
// Top level of the grouped pair weight accumulator: control sequencer, weight
// arithmetic and flush scan around one score RAM.
// Depends on gpwa_pkg and gpwa_ram.
//
// Usage. A command is transferred when start is high and busy is low. A record
// command (req_mode 0) names a cell pair, a peak id and a distance; a flush
// command (req_mode 1) marks the end of the data. Each result is shown on the
// rsp_ ports for one cycle with rsp_valid high; the receiver cannot hold it off.
// Registers are written through csr_write_enable, csr_index and csr_write_data; the user
// must do so only while the block is idle, which the block does not enforce. Writes take
// effect at once and cannot be read back.
// Timing. A record of the current group passes through the square, the scaling
// multiply and the log2 multiply, 12 iterations of the shared root-factor
// multiplier, the final shift with the RAM read, and the read-modify-write of
// the score. A record with an invalid pair is dropped in its transfer cycle. A
// flush scans all 55 entries at one RAM read a cycle; results leave in index
// order. A qualifying entry is held until the next one is found, so the first
// result leaves only when a second one is found or the scan ends, and the last
// one appears in the cycle right after the flush ends. A record that opens a
// new group runs the flush of the old group first and then its own weight update.
//
// Reset (synchronous, active high) restores the register defaults, sets the
// current peak id to zero and clears the per-entry valid flags, so the whole
// score store reads as zero at once; no clearing pass is needed.
module grouped_pair_weight_accumulator #(
   parameter int MAX_CELLS   = gpwa_pkg::MAX_CELLS_DEF,
   parameter int SCORE_WIDTH = gpwa_pkg::SCORE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_mode,
   input  logic [gpwa_pkg::CELL_W-1:0]      req_first_cell,
   input  logic [gpwa_pkg::CELL_W-1:0]      req_second_cell,
   input  logic [gpwa_pkg::PEAK_W-1:0]      req_peak_id,
   input  logic [gpwa_pkg::DIST_W-1:0]      req_distance,
   output logic                             rsp_valid,
   output logic [gpwa_pkg::PAIR_W-1:0]      rsp_pair_index,
   output logic [gpwa_pkg::PEAK_W-1:0]      rsp_group_peak,
   output logic [gpwa_pkg::SCORE_W-1:0]     rsp_score,
   output logic                             rsp_last,
   input  logic                             csr_write_enable,
   input  logic [gpwa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gpwa_pkg::CSR_W-1:0]       csr_write_data
);

   localparam int DEPTH  = MAX_CELLS * (MAX_CELLS - 1) / 2;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W  = (SCORE_WIDTH > gpwa_pkg::THRESH_W) ? SCORE_WIDTH
                                                             : gpwa_pkg::THRESH_W;
   localparam int PW     = gpwa_pkg::PAIR_W;
   localparam int CW     = gpwa_pkg::CELL_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [3:0] LAST_STEP = 4'(gpwa_pkg::ROOT_STEPS - 1);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_SCAN  = 10'b00_0000_0010,
      ST_DRAIN = 10'b00_0000_0100,
      ST_FINAL = 10'b00_0000_1000,
      ST_SQ    = 10'b00_0001_0000,
      ST_XP    = 10'b00_0010_0000,
      ST_Y     = 10'b00_0100_0000,
      ST_ROOT  = 10'b00_1000_0000,
      ST_SHIFT = 10'b01_0000_0000,
      ST_WRITE = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [CW-1:0]                      cell_count_ff, cell_count_in;
   logic [gpwa_pkg::INV_W-1:0]         inv_sd_ff, inv_sd_in;
   logic [gpwa_pkg::THRESH_W-1:0]      threshold_ff, threshold_in;

   // Command context.
   logic                               after_acc_ff, after_acc_in;
   logic [gpwa_pkg::PEAK_W-1:0]        peak_ff, peak_in;
   logic [gpwa_pkg::PEAK_W-1:0]        cur_peak_ff, cur_peak_in;
   logic [ADDR_W-1:0]                  addr_ff, addr_in;
   logic [gpwa_pkg::DIST_W-1:0]        dist_ff, dist_in;

   // Weight datapath.
   logic [31:0]                        sq_ff, sq_in;
   logic [63:0]                        p_ff, p_in;
   logic [21:0]                        y_ff, y_in;
   logic                               kill_ff, kill_in;
   logic [30:0]                        m_ff, m_in;
   logic [3:0]                         step_ff, step_in;
   logic [gpwa_pkg::WEIGHT_W-1:0]      weight_ff, weight_in;

   // Flush scan.
   logic [ADDR_W-1:0]                  scan_addr_ff, scan_addr_in;
   logic                               rd_pend_ff, rd_pend_in;
   logic [ADDR_W-1:0]                  rd_idx_ff, rd_idx_in;
   logic                               rd_vbit_ff, rd_vbit_in;
   logic                               pend_have_ff, pend_have_in;
   logic [ADDR_W-1:0]                  pend_idx_ff, pend_idx_in;
   logic [SCORE_WIDTH-1:0]             pend_score_ff, pend_score_in;
   logic [DEPTH-1:0]                   valid_ff, valid_in;

   // Result register.
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]                      rsp_pair_ff, rsp_pair_in;
   logic [gpwa_pkg::PEAK_W-1:0]        rsp_peak_ff, rsp_peak_in;
   logic [gpwa_pkg::SCORE_W-1:0]       rsp_score_ff, rsp_score_in;
   logic                               rsp_last_ff, rsp_last_in;

   // RAM ports.
   logic                               ram_wr_en;
   logic [SCORE_WIDTH-1:0]             ram_wr_data;
   logic                               ram_rd_en;
   logic [ADDR_W-1:0]                  ram_rd_addr;
   logic [SCORE_WIDTH-1:0]             ram_rd_data;

   // Combinational helpers.
   logic [CW-1:0]                      cells;
   logic                               pair_ok;
   logic [7:0]                         b_ext;
   logic [7:0]                         tri_base;
   logic [7:0]                         tri_idx;
   logic [47:0]                        x16;
   logic [53:0]                        y_prod;
   logic [60:0]                        m_prod;
   logic [5:0]                         n_int;
   logic [11:0]                        f_bits;
   logic [5:0]                         shift_amt;
   logic [30:0]                        w_full;
   logic [SCORE_WIDTH-1:0]             old_score;
   logic [SCORE_WIDTH:0]               sum_wide;
   logic [SCORE_WIDTH-1:0]             scan_score;
   logic                               hit;
   logic [CMP_W-1:0]                   pend_score_ext;

   gpwa_ram #(
      .WIDTH (SCORE_WIDTH),
      .DEPTH (DEPTH),
      .ADDR_W(ADDR_W)
   ) u_score_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(addr_ff),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Pair check and triangular index. The cell count is clamped into range.
   always_comb begin
      if (cell_count_ff < CW'(2)) begin
         cells = CW'(2);
      end else if (cell_count_ff > CW'(MAX_CELLS)) begin
         cells = CW'(MAX_CELLS);
      end else begin
         cells = cell_count_ff;
      end
      pair_ok  = (req_first_cell != '0) && (req_first_cell < req_second_cell) &&
                 (req_second_cell <= cells);
      b_ext    = 8'(req_second_cell);
      tri_base = 8'(((b_ext - 8'd1) * (b_ext - 8'd2)) >> 1);
      tri_idx  = tri_base + 8'(req_first_cell);
   end

   // Weight arithmetic: the exponent in Q16, its log2 scaling, and one
   // root factor multiply per iteration.
   always_comb begin
      x16       = p_ff[63:16];
      y_prod    = {32'b0, x16[21:0]} * {22'b0, gpwa_pkg::LOG2_K};
      n_int     = y_ff[21:16];
      f_bits    = y_ff[15:4];
      m_prod    = {30'b0, m_ff} * {31'b0, gpwa_pkg::root_factor(step_ff)};
      shift_amt = 6'd14 + n_int;
      w_full    = m_ff >> shift_amt;
   end

   // Score update with saturation, and the effective score seen by the scan.
   always_comb begin
      old_score   = valid_ff[addr_ff] ? ram_rd_data : '0;
      sum_wide    = {1'b0, old_score} + (SCORE_WIDTH + 1)'(weight_ff);
      ram_wr_data = sum_wide[SCORE_WIDTH] ? {SCORE_WIDTH{1'b1}} : sum_wide[SCORE_WIDTH-1:0];
      scan_score  = rd_vbit_ff ? ram_rd_data : '0;
      hit         = rd_pend_ff &&
                    (CMP_W'(scan_score) > CMP_W'(threshold_ff));
      pend_score_ext = CMP_W'(pend_score_ff);
      ram_wr_en   = (state_ff == ST_WRITE);
      ram_rd_en   = (state_ff == ST_SCAN) || (state_ff == ST_SHIFT);
      ram_rd_addr = (state_ff == ST_SCAN) ? scan_addr_ff : addr_ff;
   end

   always_comb begin
      state_in      = state_ff;
      cell_count_in = cell_count_ff;
      inv_sd_in     = inv_sd_ff;
      threshold_in  = threshold_ff;
      after_acc_in  = after_acc_ff;
      peak_in       = peak_ff;
      cur_peak_in   = cur_peak_ff;
      addr_in       = addr_ff;
      dist_in       = dist_ff;
      sq_in         = sq_ff;
      p_in          = p_ff;
      y_in          = y_ff;
      kill_in       = kill_ff;
      m_in          = m_ff;
      step_in       = step_ff;
      weight_in     = weight_ff;
      scan_addr_in  = scan_addr_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      rd_vbit_in    = rd_vbit_ff;
      pend_have_in  = pend_have_ff;
      pend_idx_in   = pend_idx_ff;
      pend_score_in = pend_score_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_pair_in   = PW'({1'b0, pend_idx_ff} + (ADDR_W + 1)'(1));
      rsp_peak_in   = cur_peak_ff;
      rsp_score_in  = pend_score_ext[gpwa_pkg::SCORE_W-1:0];
      rsp_last_in   = (state_ff == ST_FINAL);

      if (csr_write_enable) begin
         unique case (csr_index)
            gpwa_pkg::CSR_CELL_COUNT:     cell_count_in = csr_write_data[CW-1:0];
            gpwa_pkg::CSR_INV_SD_SQUARED: inv_sd_in = csr_write_data;
            gpwa_pkg::CSR_EMIT_THRESHOLD:
               threshold_in = csr_write_data[gpwa_pkg::THRESH_W-1:0];
            default: ;
         endcase
      end

      // A qualifying entry found by the scan releases the one held before it;
      // the entry still held when the scan ends is the last of the flush.
      if (hit) begin
         rsp_valid_in  = pend_have_ff;
         pend_have_in  = 1'b1;
         pend_idx_in   = rd_idx_ff;
         pend_score_in = scan_score;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_mode) begin
                  after_acc_in = 1'b0;
                  scan_addr_in = '0;
                  state_in     = ST_SCAN;
               end else if (pair_ok) begin
                  addr_in = ADDR_W'(tri_idx - 8'd1);
                  dist_in = req_distance;
                  peak_in = req_peak_id;
                  if (req_peak_id != cur_peak_ff) begin
                     after_acc_in = 1'b1;
                     scan_addr_in = '0;
                     state_in     = ST_SCAN;
                  end else begin
                     state_in = ST_SQ;
                  end
               end
            end
         end
         ST_SCAN: begin
            rd_pend_in   = 1'b1;
            rd_idx_in    = scan_addr_ff;
            rd_vbit_in   = valid_ff[scan_addr_ff];
            scan_addr_in = scan_addr_ff + ADDR_W'(1);
            if (scan_addr_ff == LAST_ADDR) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            rsp_valid_in = pend_have_ff;
            pend_have_in = 1'b0;
            valid_in     = '0;
            if (after_acc_ff) begin
               cur_peak_in = peak_ff;
               state_in    = ST_SQ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SQ: begin
            sq_in    = {16'b0, dist_ff} * {16'b0, dist_ff};
            state_in = ST_XP;
         end
         ST_XP: begin
            p_in     = {32'b0, sq_ff} * {32'b0, inv_sd_ff};
            state_in = ST_Y;
         end
         ST_Y: begin
            kill_in  = (x16 >= gpwa_pkg::X16_LIMIT);
            y_in     = y_prod[53:32];
            m_in     = 31'h4000_0000;
            step_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (f_bits[4'd11 - step_ff]) begin
               m_in = m_prod[60:30];
            end
            step_in = step_ff + 4'd1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (kill_ff || (n_int >= gpwa_pkg::N_LIMIT)) begin
               weight_in = '0;
            end else if (w_full > 31'(16'hFFFF)) begin
               weight_in = '1;
            end else begin
               weight_in = w_full[gpwa_pkg::WEIGHT_W-1:0];
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            valid_in[addr_ff] = 1'b1;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cell_count_ff <= gpwa_pkg::CELL_COUNT_RST;
         inv_sd_ff     <= gpwa_pkg::INV_SD_RST;
         threshold_ff  <= gpwa_pkg::THRESHOLD_RST;
         cur_peak_ff   <= '0;
         after_acc_ff  <= 1'b0;
         rd_pend_ff    <= 1'b0;
         pend_have_ff  <= 1'b0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cell_count_ff <= cell_count_in;
         inv_sd_ff     <= inv_sd_in;
         threshold_ff  <= threshold_in;
         cur_peak_ff   <= cur_peak_in;
         after_acc_ff  <= after_acc_in;
         rd_pend_ff    <= rd_pend_in;
         pend_have_ff  <= pend_have_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      peak_ff       <= peak_in;
      addr_ff       <= addr_in;
      dist_ff       <= dist_in;
      sq_ff         <= sq_in;
      p_ff          <= p_in;
      y_ff          <= y_in;
      kill_ff       <= kill_in;
      m_ff          <= m_in;
      step_ff       <= step_in;
      weight_ff     <= weight_in;
      scan_addr_ff  <= scan_addr_in;
      rd_idx_ff     <= rd_idx_in;
      rd_vbit_ff    <= rd_vbit_in;
      pend_idx_ff   <= pend_idx_in;
      pend_score_ff <= pend_score_in;
      rsp_pair_ff   <= rsp_pair_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pair_index = rsp_pair_ff;
   assign rsp_group_peak = rsp_peak_ff;
   assign rsp_score      = rsp_score_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== dv/tb_grouped_pair_weight_accumulator.sv =====
// Self-checking testbench for the grouped pair weight accumulator: directed commands, then
// randomized groups of pair records under several register settings, checked by a predictor.
// Depends on gpwa_pkg and the grouped_pair_weight_accumulator RTL.
module tb_grouped_pair_weight_accumulator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 10;
   localparam int STORE_DEPTH  = 55;
   localparam int PHASE_ITEMS  = 28;
   localparam int SETTLE_WAIT  = 24;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 500000;

   localparam int CELL_W    = gpwa_pkg::CELL_W;
   localparam int PEAK_W    = gpwa_pkg::PEAK_W;
   localparam int DIST_W    = gpwa_pkg::DIST_W;
   localparam int PAIR_W    = gpwa_pkg::PAIR_W;
   localparam int SCORE_W   = gpwa_pkg::SCORE_W;
   localparam int THRESH_W  = gpwa_pkg::THRESH_W;
   localparam int INV_W     = gpwa_pkg::INV_W;
   localparam int CSR_W     = gpwa_pkg::CSR_W;
   localparam int CSR_IDX_W = gpwa_pkg::CSR_IDX_W;
   localparam int WEIGHT_W  = gpwa_pkg::WEIGHT_W;

   // Command codes carried on req_mode.
   typedef enum logic {
      OP_RECORD = 1'b0,
      OP_FLUSH  = 1'b1
   } op_type;

   // One emitted score entry, as it appears on the rsp_ ports.
   typedef struct packed {
      logic [PAIR_W-1:0]  pair;
      logic [PEAK_W-1:0]  peak;
      logic [SCORE_W-1:0] score;
      logic               last;
   } emission_type;

   // A directed command. Pinned rows carry their expectation in the table: either nothing,
   // or exactly the one result given in res. Other rows go through the predictor.
   typedef struct packed {
      op_type             op;
      logic [CELL_W-1:0]  first_cell;
      logic [CELL_W-1:0]  second_cell;
      logic [PEAK_W-1:0]  peak;
      logic [DIST_W-1:0]  distance;
      logic               pinned;
      logic               emits;
      emission_type       res;
   } script_row_type;

   // Register contents for one random phase, plus whether the sender may pause.
   typedef struct packed {
      logic [CELL_W-1:0]   cells;
      logic [INV_W-1:0]    inv;
      logic [THRESH_W-1:0] thresh;
      logic                gaps;
   } setting_type;

   // log2(1/0.7788) as an unsigned Q0.32 fraction.
   localparam logic [31:0] LOG2_INV_DECAY = 32'd1549088188;

   // 2^-(2^-(k+1)) in Q1.30; entry 0 belongs to the half bit of the fraction.
   localparam logic [29:0] HALVING_ROOTS [0:11] = '{
      30'd759250125,  30'd902905651,  30'd984625594,  30'd1028218694,
      30'd1050733823, 30'd1062175527, 30'd1067943017, 30'd1070838496,
      30'd1072289178, 30'd1073015255, 30'd1073378480, 30'd1073560135
   };

   // The directed part runs with the reset register values: all 11 cells, a spread of
   // about one and a threshold of about 0.01. Distance zero always weighs 65535.
   localparam int SCRIPT_LEN = 22;
   localparam script_row_type SCRIPT [0:SCRIPT_LEN-1] = '{
      // Two full weights into pair (1,2) of the reset group, peak zero: nothing leaves yet.
      '{OP_RECORD, 4'd1,  4'd2,  24'h000000, 16'd0,     1'b1, 1'b0, '0},
      '{OP_RECORD, 4'd1,  4'd2,  24'h000000, 16'd0,     1'b1, 1'b0, '0},
      // End of data emits the doubled score as the only, and so last, result.
      '{OP_FLUSH,  4'd0,  4'd0,  24'h000000, 16'd0,     1'b1, 1'b1,
        '{6'd1, 24'h000000, 24'd131070, 1'b1}},
      // A second end of data finds the store empty; every field at its maximum.
      '{OP_FLUSH,  4'hF,  4'hF,  24'hFFFFFF, 16'hFFFF,  1'b1, 1'b0, '0},
      // Invalid pairs: first cell zero, equal cells, swapped cells, beyond the cell count.
      // They must not flush even though the peak id differs.
      '{OP_RECORD, 4'd0,  4'd2,  24'h000005, 16'd0,     1'b1, 1'b0, '0},
      '{OP_RECORD, 4'd3,  4'd3,  24'h000005, 16'd0,     1'b1, 1'b0, '0},
      '{OP_RECORD, 4'd2,  4'd1,  24'h000005, 16'd0,     1'b1, 1'b0, '0},
      '{OP_RECORD, 4'd1,  4'd12, 24'h000005, 16'd0,     1'b1, 1'b0, '0},
      '{OP_RECORD, 4'hF,  4'hF,  24'h000005, 16'd0,     1'b1, 1'b0, '0},
      // New peak id on the highest pair index: flushes an empty store.
      '{OP_RECORD, 4'd10, 4'd11, 24'hFFFFFF, 16'd0,     1'b1, 1'b0, '0},
      // Largest distance weighs nothing; the rest of the group stays inside the store.
      '{OP_RECORD, 4'd1,  4'd11, 24'hFFFFFF, 16'hFFFF,  1'b1, 1'b0, '0},
      '{OP_RECORD, 4'd1,  4'd2,  24'hFFFFFF, 16'd1,     1'b1, 1'b0, '0},
      '{OP_RECORD, 4'd2,  4'd3,  24'hFFFFFF, 16'd3,     1'b1, 1'b0, '0},
      '{OP_RECORD, 4'd4,  4'd7,  24'hFFFFFF, 16'd5,     1'b1, 1'b0, '0},
      '{OP_RECORD, 4'd9,  4'd10, 24'hFFFFFF, 16'd6,     1'b1, 1'b0, '0},
      '{OP_RECORD, 4'd3,  4'd4,  24'hFFFFFF, 16'd7,     1'b1, 1'b0, '0},
      // Back to peak zero: the mixed group above leaves through the predictor.
      '{OP_RECORD, 4'd1,  4'd2,  24'h000000, 16'd0,     1'b0, 1'b0, '0},
      // End of data ignores its peak id and keeps the current one.
      '{OP_FLUSH,  4'hF,  4'hF,  24'hABCDEF, 16'd1234,  1'b1, 1'b1,
        '{6'd1, 24'h000000, 24'd65535, 1'b1}},
      '{OP_RECORD, 4'd1,  4'd2,  24'h000000, 16'd2,     1'b1, 1'b0, '0},
      '{OP_FLUSH,  4'd0,  4'd0,  24'h000000, 16'd0,     1'b0, 1'b0, '0},
      '{OP_RECORD, 4'd2,  4'd5,  24'h123456, 16'd0,     1'b1, 1'b0, '0},
      '{OP_FLUSH,  4'd0,  4'd0,  24'h000000, 16'd0,     1'b1, 1'b1,
        '{6'd8, 24'h123456, 24'd65535, 1'b1}}
   };

   // Random phases. Cell counts 1 and 15 lie outside the usable range and are clamped.
   // The last phase runs without sender pauses.
   localparam int N_PHASES = 6;
   localparam setting_type PHASES [0:N_PHASES-1] = '{
      '{4'd11, 32'hFFFF_FFFF, 24'd655,      1'b1},
      '{4'd2,  32'h0000_0001, 24'd0,        1'b1},
      '{4'd5,  32'h0001_0000, 24'hFFFFFF,   1'b1},
      '{4'd1,  32'h1000_0000, 24'd20000,    1'b1},
      '{4'd15, 32'h0040_0000, 24'd1000,     1'b1},
      '{4'd7,  32'h8000_0000, 24'd65535,    1'b0}
   };

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_mode;
   logic [CELL_W-1:0]     req_first_cell;
   logic [CELL_W-1:0]     req_second_cell;
   logic [PEAK_W-1:0]     req_peak_id;
   logic [DIST_W-1:0]     req_distance;
   logic                  rsp_valid;
   logic [PAIR_W-1:0]     rsp_pair_index;
   logic [PEAK_W-1:0]     rsp_group_peak;
   logic [SCORE_W-1:0]    rsp_score;
   logic                  rsp_last;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_W-1:0]      csr_write_data;

   // Predictor state: its own copy of the score store, the current group and the registers.
   logic [SCORE_W-1:0]    model_score [0:STORE_DEPTH-1];
   logic [PEAK_W-1:0]     model_peak;
   logic [CELL_W-1:0]     model_cells;
   logic [INV_W-1:0]      model_inv;
   logic [THRESH_W-1:0]   model_thresh;

   // Results of the last predicted command, and all results still owed by the block.
   emission_type          step_out [$];
   emission_type          pending_emissions [$];

   int                    failures;
   int                    cycle_count;

   grouped_pair_weight_accumulator u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_first_cell   (req_first_cell),
      .req_second_cell  (req_second_cell),
      .req_peak_id      (req_peak_id),
      .req_distance     (req_distance),
      .rsp_valid        (rsp_valid),
      .rsp_pair_index   (rsp_pair_index),
      .rsp_group_peak   (rsp_group_peak),
      .rsp_score        (rsp_score),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   // The cell count register is clamped to 2..11 wherever it is used.
   function automatic int usable_cells();
      int cells;
      cells = model_cells;
      if (cells < 2) cells = 2;
      if (cells > gpwa_pkg::MAX_CELLS_DEF) cells = gpwa_pkg::MAX_CELLS_DEF;
      return cells;
   endfunction

   // Weight 0.7788^(d^2 / sd^2) in Q0.16. The exponent is turned into a power of two:
   // the integer part becomes a shift and the top 12 fraction bits pick table factors,
   // with truncation after every multiply.
   function automatic logic [WEIGHT_W-1:0] decay_weight(input logic [DIST_W-1:0] distance,
                                                        input logic [INV_W-1:0]  inv);
      logic [63:0] expo;
      logic [63:0] pow2;
      logic [63:0] mant;
      logic [63:0] w;
      logic [4:0]  whole;
      logic [11:0] frac;
      expo = (64'(distance) * 64'(distance) * 64'(inv)) >> 16;
      if (expo >= (64'd48 << 16)) return '0;
      pow2 = (expo * 64'(LOG2_INV_DECAY)) >> 32;
      if ((pow2 >> 16) >= 64'd17) return '0;
      whole = pow2[20:16];
      frac  = pow2[15:4];
      mant  = 64'd1 << 30;
      for (int k = 0; k < 12; k++) begin
         if (frac[11-k]) mant = (mant * 64'(HALVING_ROOTS[k])) >> 30;
      end
      w = mant >> (14 + whole);
      return (w > 64'd65535) ? 16'hFFFF : w[15:0];
   endfunction

   // Scan the whole store in index order, emit the entries above the threshold under the
   // current peak id, mark the final one, and clear everything.
   function automatic void drain_scores();
      int           n_out;
      emission_type tail;
      n_out = 0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (model_score[i] > model_thresh) begin
            step_out.push_back('{PAIR_W'(i + 1), model_peak, model_score[i], 1'b0});
            n_out++;
         end
         model_score[i] = '0;
      end
      if (n_out > 0) begin
         tail = step_out.pop_back();
         tail.last = 1'b1;
         step_out.push_back(tail);
      end
   endfunction

   // Expected results of one accepted command, left in step_out.
   function automatic void predict_emissions(input op_type            op,
                                             input logic [CELL_W-1:0] first_cell,
                                             input logic [CELL_W-1:0] second_cell,
                                             input logic [PEAK_W-1:0] peak,
                                             input logic [DIST_W-1:0] distance);
      int               lo;
      int               hi;
      int               idx;
      logic [SCORE_W:0] sum;
      step_out.delete();
      lo = first_cell;
      hi = second_cell;
      if (op == OP_FLUSH) begin
         drain_scores();
         return;
      end
      if (lo < 1 || lo >= hi || hi > usable_cells()) return;
      if (peak != model_peak) begin
         drain_scores();
         model_peak = peak;
      end
      idx = (hi - 1) * (hi - 2) / 2 + lo;
      sum = model_score[idx-1] + decay_weight(distance, model_inv);
      model_score[idx-1] = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
   endfunction

   // Present one command from a falling edge on and hold it until a rising edge sees start
   // high and busy low; that edge is the transfer. Unless the row pins its own expectation,
   // the predicted results join the pending list right away.
   task automatic transfer_cmd(input op_type            op,
                               input logic [CELL_W-1:0] first_cell,
                               input logic [CELL_W-1:0] second_cell,
                               input logic [PEAK_W-1:0] peak,
                               input logic [DIST_W-1:0] distance,
                               input logic              pinned);
      @(negedge clock);
      start           = 1'b1;
      req_mode        = op;
      req_first_cell  = first_cell;
      req_second_cell = second_cell;
      req_peak_id     = peak;
      req_distance    = distance;
      do @(posedge clock); while (busy !== 1'b0);
      predict_emissions(op, first_cell, second_cell, peak, distance);
      if (!pinned) begin
         foreach (step_out[i]) pending_emissions.push_back(step_out[i]);
      end
   endtask

   // Register write through the plain write port; the predictor follows at once.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         gpwa_pkg::CSR_CELL_COUNT:     model_cells  = data[CELL_W-1:0];
         gpwa_pkg::CSR_INV_SD_SQUARED: model_inv    = data[INV_W-1:0];
         gpwa_pkg::CSR_EMIT_THRESHOLD: model_thresh = data[THRESH_W-1:0];
         default: ;
      endcase
   endtask

   // Bring the block to rest before touching its registers. A record that causes no result
   // can still be in its read-modify-write when the last owed result leaves, so a settling
   // wait of SETTLE_WAIT passes after the list empties, and busy must be low as well.
   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (pending_emissions.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // Every result strobe is taken at the rising edge that ends its cycle and compared with
   // the oldest owed result. The receiver has no way to stall, so nothing is driven here.
   always @(posedge clock) begin : check_results
      emission_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_emissions.size() == 0) begin
            $error("unexpected result: pair_index %0d group_peak %0h score %0d last %0b",
                   rsp_pair_index, rsp_group_peak, rsp_score, rsp_last);
            failures++;
         end else begin
            want = pending_emissions.pop_front();
            if (rsp_pair_index !== want.pair) begin
               $error("pair_index: expected %0d, actual %0d", want.pair, rsp_pair_index);
               failures++;
            end
            if (rsp_group_peak !== want.peak) begin
               $error("group_peak: expected %0h, actual %0h", want.peak, rsp_group_peak);
               failures++;
            end
            if (rsp_score !== want.score) begin
               $error("score: expected %0d, actual %0d", want.score, rsp_score);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_last);
               failures++;
            end
         end
      end
   end

   // Hard stop in case the block hangs or never delivers an owed result.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_grouped_pair_weight_accumulator: errors");
         $finish;
      end
   end

   initial begin : stimulus
      script_row_type         row;
      op_type                 op;
      logic [CELL_W-1:0]      first_cell;
      logic [CELL_W-1:0]      second_cell;
      logic [PEAK_W-1:0]      peak;
      logic [PEAK_W-1:0]      group_peak;
      logic [DIST_W-1:0]      distance;
      int                     sent;
      int                     group_len;
      int                     roll;
      int                     gap;
      bit                     counts;

      failures         = 0;
      cycle_count      = 0;
      reset            = 1'b1;
      start            = 1'b0;
      req_mode         = OP_RECORD;
      req_first_cell   = '0;
      req_second_cell  = '0;
      req_peak_id      = '0;
      req_distance     = '0;
      csr_write_enable = 1'b0;
      csr_index        = gpwa_pkg::CSR_CELL_COUNT;
      csr_write_data   = '0;

      // The predictor starts from the reset state: default registers, peak zero, empty store.
      model_cells  = gpwa_pkg::CELL_COUNT_RST;
      model_inv    = gpwa_pkg::INV_SD_RST;
      model_thresh = gpwa_pkg::THRESHOLD_RST;
      model_peak   = '0;
      foreach (model_score[i]) model_score[i] = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed commands back to back, straight after reset, so the register defaults are
      // exercised too.
      for (int r = 0; r < SCRIPT_LEN; r++) begin
         row = SCRIPT[r];
         transfer_cmd(row.op, row.first_cell, row.second_cell, row.peak, row.distance,
                      row.pinned);
         if (row.pinned && row.emits) pending_emissions.push_back(row.res);
      end

      // Random phases. Groups are runs of valid records sharing one peak id, so scores
      // accumulate and every group change causes a scan. Sprinkled among them are end of
      // data commands and noise records with arbitrary pair fields. The open group carries
      // over a register change, which also lowers the cell count in the middle of a group.
      for (int p = 0; p < N_PHASES; p++) begin
         settle();
         write_reg(gpwa_pkg::CSR_CELL_COUNT,     CSR_W'(PHASES[p].cells));
         write_reg(gpwa_pkg::CSR_INV_SD_SQUARED, CSR_W'(PHASES[p].inv));
         write_reg(gpwa_pkg::CSR_EMIT_THRESHOLD, CSR_W'(PHASES[p].thresh));
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) group_peak = model_peak;
            else if (roll == 1) group_peak = $urandom_range(0, 1) ? '1 : '0;
            else group_peak = PEAK_W'($urandom);
            group_len = $urandom_range(1, 8);
            for (int g = 0; g < group_len && sent < PHASE_ITEMS; g++) begin
               // A pause now and then, landing wherever the block is.
               if (PHASES[p].gaps && $urandom_range(0, 3) == 0) begin
                  gap = $urandom_range(1, 6);
                  @(negedge clock);
                  start = 1'b0;
                  repeat (gap - 1) @(negedge clock);
               end
               roll = $urandom_range(0, 99);
               if (roll < 6) begin
                  op          = OP_FLUSH;
                  first_cell  = CELL_W'($urandom);
                  second_cell = CELL_W'($urandom);
                  peak        = PEAK_W'($urandom);
               end else if (roll < 16) begin
                  op          = OP_RECORD;
                  first_cell  = CELL_W'($urandom);
                  second_cell = CELL_W'($urandom);
                  peak        = $urandom_range(0, 1) ? group_peak : PEAK_W'($urandom);
               end else begin
                  op          = OP_RECORD;
                  second_cell = CELL_W'($urandom_range(2, usable_cells()));
                  first_cell  = CELL_W'($urandom_range(1, second_cell - 1));
                  peak        = group_peak;
               end
               // Shifting by a random amount spreads distances over all magnitudes, so
               // distances of every magnitude reach the weight arithmetic.
               distance = DIST_W'($urandom) >> $urandom_range(0, 15);
               // Records that the block drops do not count toward the phase.
               counts = (op == OP_FLUSH) ||
                        (first_cell >= 1 && first_cell < second_cell &&
                         int'(second_cell) <= usable_cells());
               transfer_cmd(op, first_cell, second_cell, peak, distance, 1'b0);
               if (counts) sent++;
            end
         end
      end

      // All commands are in; wait for every owed result, then long enough for a stray one.
      @(negedge clock);
      start = 1'b0;
      while (pending_emissions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("tb_grouped_pair_weight_accumulator: clean");
      end else begin
         $display("tb_grouped_pair_weight_accumulator: errors");
      end
      $finish;
   end

endmodule
